// File: sv/hclc_pkg.sv
`timescale 1ns / 1ps
package hclc_pkg;

	localparam int HOT_ENTRIES_D         = 8;
	localparam int FIRST_CAND_ENTRIES_D  = 8;
	localparam int SECOND_CAND_ENTRIES_D = 16;
	localparam int ADDR_BITS_D           = 16;

	localparam int IN_ADDR_W = 16;

	localparam logic [1:0] LVL_NONE   = 2'd0;
	localparam logic [1:0] LVL_SECOND = 2'd1;
	localparam logic [1:0] LVL_FIRST  = 2'd2;
	localparam logic [1:0] LVL_HOT    = 2'd3;

	typedef struct packed {
		logic capture;
		logic update;
	} cmd_t;

endpackage

// File: sv/hclc_controller.sv
`timescale 1ns / 1ps
module hclc_controller
	import hclc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output cmd_t cmd
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_UPDATE = 1'b1;

	logic state_q;
	logic done_q;

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign cmd.capture = start && (state_q == ST_IDLE);
	assign cmd.update  = (state_q == ST_UPDATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.update;
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/hclc_datapath.sv
`timescale 1ns / 1ps
module hclc_datapath
	import hclc_pkg::*;
#(
	parameter int HOT_ENTRIES         = HOT_ENTRIES_D,
	parameter int FIRST_CAND_ENTRIES  = FIRST_CAND_ENTRIES_D,
	parameter int SECOND_CAND_ENTRIES = SECOND_CAND_ENTRIES_D,
	parameter int ADDR_BITS           = ADDR_BITS_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic [IN_ADDR_W-1:0] logical_address,
	output logic                 was_hot,
	output logic [1:0]           found_level
);

	localparam int HN  = HOT_ENTRIES;
	localparam int FN  = FIRST_CAND_ENTRIES;
	localparam int SN  = SECOND_CAND_ENTRIES;
	localparam int AW  = ADDR_BITS;
	localparam int HIW = (HN > 1) ? $clog2(HN) : 1;
	localparam int FIW = (FN > 1) ? $clog2(FN) : 1;
	localparam int SIW = (SN > 1) ? $clog2(SN) : 1;
	localparam int HCW = $clog2(HN + 1);
	localparam int FCW = $clog2(FN + 1);
	localparam int SCW = $clog2(SN + 1);

	logic [AW-1:0]  hot_q [HN];
	logic [AW-1:0]  first_q [FN];
	logic [AW-1:0]  second_q [SN];
	logic [HCW-1:0] hot_cnt_q;
	logic [FCW-1:0] first_cnt_q;
	logic [SCW-1:0] second_cnt_q;

	logic [AW-1:0]  addr_q;
	logic [1:0]     lvl_q;
	logic [HIW-1:0] hot_idx_q;
	logic [FIW-1:0] first_idx_q;
	logic [SIW-1:0] second_idx_q;
	logic           was_hot_q;
	logic [1:0]     found_level_q;

	logic [AW-1:0]  addr_in;
	logic           hot_hit, first_hit, second_hit;
	logic [HIW-1:0] hot_idx;
	logic [FIW-1:0] first_idx;
	logic [SIW-1:0] second_idx;
	logic [1:0]     lvl_in;

	logic [AW-1:0]  hot_d [HN];
	logic [AW-1:0]  first_d [FN];
	logic [AW-1:0]  second_d [SN];
	logic [HCW-1:0] hot_cnt_d;
	logic [FCW-1:0] first_cnt_d;
	logic [SCW-1:0] second_cnt_d;

	assign addr_in     = AW'(logical_address);
	assign was_hot     = was_hot_q;
	assign found_level = found_level_q;

	// parallel lookup, lowest slot wins
	always_comb begin
		hot_hit    = 1'b0;
		hot_idx    = '0;
		first_hit  = 1'b0;
		first_idx  = '0;
		second_hit = 1'b0;
		second_idx = '0;
		for (int k = HN - 1; k >= 0; k--) begin
			if ((HCW'(k) < hot_cnt_q) && (hot_q[k] == addr_in)) begin
				hot_hit = 1'b1;
				hot_idx = HIW'(k);
			end
		end
		for (int k = FN - 1; k >= 0; k--) begin
			if ((FCW'(k) < first_cnt_q) && (first_q[k] == addr_in)) begin
				first_hit = 1'b1;
				first_idx = FIW'(k);
			end
		end
		for (int k = SN - 1; k >= 0; k--) begin
			if ((SCW'(k) < second_cnt_q) && (second_q[k] == addr_in)) begin
				second_hit = 1'b1;
				second_idx = SIW'(k);
			end
		end
		if (hot_hit)         lvl_in = LVL_HOT;
		else if (first_hit)  lvl_in = LVL_FIRST;
		else if (second_hit) lvl_in = LVL_SECOND;
		else                 lvl_in = LVL_NONE;
	end

	// list update
	always_comb begin
		hot_d        = hot_q;
		first_d      = first_q;
		second_d     = second_q;
		hot_cnt_d    = hot_cnt_q;
		first_cnt_d  = first_cnt_q;
		second_cnt_d = second_cnt_q;
		case (lvl_q)
			LVL_HOT: begin
				hot_d[0] = addr_q;
				for (int k = 1; k < HN; k++) begin
					if (HIW'(k) <= hot_idx_q) hot_d[k] = hot_q[k-1];
				end
			end
			LVL_FIRST: begin
				hot_d[0] = addr_q;
				for (int k = 1; k < HN; k++) hot_d[k] = hot_q[k-1];
				if (hot_cnt_q == HCW'(HN)) begin
					first_d[0] = hot_q[HN-1];
					for (int k = 1; k < FN; k++) begin
						if (FIW'(k) <= first_idx_q) first_d[k] = first_q[k-1];
					end
				end else begin
					hot_cnt_d   = hot_cnt_q + 1'b1;
					first_cnt_d = first_cnt_q - 1'b1;
					for (int k = 0; k < FN - 1; k++) begin
						if (FIW'(k) >= first_idx_q) first_d[k] = first_q[k+1];
					end
				end
			end
			LVL_SECOND: begin
				first_d[0] = addr_q;
				for (int k = 1; k < FN; k++) first_d[k] = first_q[k-1];
				if (first_cnt_q == FCW'(FN)) begin
					second_d[0] = first_q[FN-1];
					for (int k = 1; k < SN; k++) begin
						if (SIW'(k) <= second_idx_q) second_d[k] = second_q[k-1];
					end
				end else begin
					first_cnt_d  = first_cnt_q + 1'b1;
					second_cnt_d = second_cnt_q - 1'b1;
					for (int k = 0; k < SN - 1; k++) begin
						if (SIW'(k) >= second_idx_q) second_d[k] = second_q[k+1];
					end
				end
			end
			LVL_NONE: begin
				second_d[0] = addr_q;
				for (int k = 1; k < SN; k++) second_d[k] = second_q[k-1];
				if (second_cnt_q != SCW'(SN)) second_cnt_d = second_cnt_q + 1'b1;
			end
			default: begin
				hot_cnt_d = hot_cnt_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q       <= addr_in;
			lvl_q        <= lvl_in;
			hot_idx_q    <= hot_idx;
			first_idx_q  <= first_idx;
			second_idx_q <= second_idx;
		end
		if (cmd.update) begin
			hot_q         <= hot_d;
			first_q       <= first_d;
			second_q      <= second_d;
			was_hot_q     <= (lvl_q == LVL_HOT);
			found_level_q <= lvl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hot_cnt_q    <= '0;
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
		end else if (cmd.update) begin
			hot_cnt_q    <= hot_cnt_d;
			first_cnt_q  <= first_cnt_d;
			second_cnt_q <= second_cnt_d;
		end
	end

endmodule

// File: sv/hot_cold_lru_classifier_unit.sv
`timescale 1ns / 1ps
// channel  | handshake           | payload
// ---------+---------------------+------------------------------
// item in  | start, busy         | logical_address[15:0]
// result   | done (one cycle)    | was_hot, found_level[1:0]
//
// an item: lookup of all three lists on the accept edge, then the update
// state shifts the lists; done is registered from that state and is
// high in the cycle after it; start may be taken again in that same cycle
// arst_n empties all lists and returns the controller to idle
// the receiver cannot stall, so done is never held
module hot_cold_lru_classifier_unit
	import hclc_pkg::*;
#(
	parameter int HOT_ENTRIES         = HOT_ENTRIES_D,
	parameter int FIRST_CAND_ENTRIES  = FIRST_CAND_ENTRIES_D,
	parameter int SECOND_CAND_ENTRIES = SECOND_CAND_ENTRIES_D,
	parameter int ADDR_BITS           = ADDR_BITS_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [IN_ADDR_W-1:0] logical_address,
	output logic                 done,
	output logic                 was_hot,
	output logic [1:0]           found_level
);

	cmd_t cmd;

	hclc_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	hclc_datapath #(
		.HOT_ENTRIES         (HOT_ENTRIES),
		.FIRST_CAND_ENTRIES  (FIRST_CAND_ENTRIES),
		.SECOND_CAND_ENTRIES (SECOND_CAND_ENTRIES),
		.ADDR_BITS           (ADDR_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.logical_address (logical_address),
		.was_hot         (was_hot),
		.found_level     (found_level)
	);

endmodule
